// ===== design/cursor_line_edit_buffer_core_defines.svh =====
// Assertion macros shared by the cursor line-edit buffer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CURSOR_LINE_EDIT_BUFFER_CORE_DEFINES_SVH
`define CURSOR_LINE_EDIT_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define CLEBC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define CLEBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Invariant that must hold on every cycle out of reset.
`define CLEBC_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

// ===== design/clebc_pkg.sv =====
// Shared types and constants for the cursor line-edit buffer.
// Used by clebc_front, clebc_back and cursor_line_edit_buffer_core.
`timescale 1ns / 1ps

package clebc_pkg;

   // Buffer geometry.
   localparam int CAP      = 1024;
   localparam int TAIL_LEN = 10;
   localparam int CNT_W    = $clog2(CAP + 1);
   localparam int ADDR_W   = $clog2(CAP);

   // Port field widths.
   localparam int MODE_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 11;
   localparam int DEL_W   = 11;
   localparam int KIND_W  = 2;

   // Command queue between front and back (depth must be a power of two).
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Result queue at the output.
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   // Command codes as they arrive on the mode port.
   localparam logic [MODE_W-1:0] MODE_INSERT     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MOVE_LEFT  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_MOVE_RIGHT = 2'd3;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_DELETE,
      OP_MOVE_LEFT,
      OP_MOVE_RIGHT
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INS,
      KIND_DEL,
      KIND_CHR,
      KIND_EMPTY
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_TAIL_SETUP,
      ST_TAIL
   } state_type;

   // One classified command as it travels from front to back.
   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] chr;
      logic [CNT_W-1:0]  count;
   } cmd_type;

   // One result beat.
   typedef struct packed {
      kind_type          kind;
      logic [DEL_W-1:0]  deleted;
      logic [CHAR_W-1:0] chr;
      logic              full_res;
      logic              last;
   } rsp_type;

endpackage

// ===== design/clebc_front.sv =====
// Front end of the line-edit buffer: accepts command beats, decodes and
// saturates them, and holds them in a short queue. Depends on clebc_pkg.
`timescale 1ns / 1ps

module clebc_front import clebc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [CHAR_W-1:0]  req_char_in,
   input  logic [COUNT_W-1:0] req_count,
   output logic               cmd_valid,
   output cmd_type            cmd_head,
   input  logic               cmd_pop
);

   cmd_type               q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  push_ok;
   logic                  pop_ok;
   cmd_type               cmd_new;

   // Decode the mode and clamp the count at the buffer capacity.
   always_comb begin
      cmd_new     = '0;
      cmd_new.chr = req_char_in;
      case (req_mode)
         MODE_INSERT:     cmd_new.op = OP_INSERT;
         MODE_DELETE:     cmd_new.op = OP_DELETE;
         MODE_MOVE_LEFT:  cmd_new.op = OP_MOVE_LEFT;
         MODE_MOVE_RIGHT: cmd_new.op = OP_MOVE_RIGHT;
         default:         cmd_new.op = OP_INSERT;
      endcase
      if (32'(req_count) > 32'(CAP)) begin
         cmd_new.count = CNT_W'(CAP);
      end else begin
         cmd_new.count = CNT_W'(req_count);
      end
   end

   assign req_full  = (cnt_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_head  = q_ff[rd_ptr_ff];
   assign push_ok   = req_push & ~req_full;
   assign pop_ok    = cmd_pop & cmd_valid;

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CMDQ_CNT_W'(push_ok) - CMDQ_CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== design/clebc_back.sv =====
// Back end of the line-edit buffer: the two character stacks, their counts,
// the command sequencer and the result queue. Depends on clebc_pkg.
`timescale 1ns / 1ps
`include "cursor_line_edit_buffer_core_defines.svh"

module clebc_back import clebc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  cmd_type            cmd_head,
   output logic               cmd_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [DEL_W-1:0]   rsp_deleted,
   output logic [CHAR_W-1:0]  rsp_char_out,
   output logic               rsp_full_res,
   output logic               rsp_last
);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      lc_ff, lc_in;
   logic [CNT_W-1:0]      rc_ff, rc_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  dir_left_ff, dir_left_in;
   logic                  pend_ff, pend_in;
   logic                  pend_last_ff, pend_last_in;

   // Character stacks.
   logic [CHAR_W-1:0]     left_mem [CAP];
   logic [CHAR_W-1:0]     right_mem [CAP];
   logic [CHAR_W-1:0]     left_rd_ff;
   logic [CHAR_W-1:0]     right_rd_ff;
   logic                  left_re, left_we, right_re, right_we;
   logic [ADDR_W-1:0]     left_raddr, left_waddr, right_raddr, right_waddr;
   logic [CHAR_W-1:0]     left_wdata, right_wdata;

   // Result queue.
   rsp_type               rq_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] rq_wr_ptr_ff, rq_wr_ptr_in;
   logic [RSPQ_PTR_W-1:0] rq_rd_ptr_ff, rq_rd_ptr_in;
   logic [RSPQ_CNT_W-1:0] rq_cnt_ff, rq_cnt_in;
   logic [RSPQ_CNT_W:0]   rq_slots;
   logic                  room;
   logic                  rq_push;
   logic                  rq_pop;
   rsp_type               rq_wdata;
   rsp_type               rq_head;

   logic                  take;
   logic [CNT_W-1:0]      n_left, n_right, tail_m;
   logic [CNT_W-1:0]      lc_m1, rc_m1;
   logic                  is_full;

   // Result slots in use, counting a pending stack read as a reserved slot.
   assign rq_slots = (RSPQ_CNT_W+1)'(rq_cnt_ff) + (RSPQ_CNT_W+1)'(pend_ff);
   assign room     = rq_slots < (RSPQ_CNT_W+1)'(RSPQ_DEPTH);
   assign take     = (state_ff == ST_IDLE) && cmd_valid && room;
   assign cmd_pop  = take;

   // Clamps and helper arithmetic.
   assign n_left  = (cmd_head.count < lc_ff) ? cmd_head.count : lc_ff;
   assign n_right = (cmd_head.count < rc_ff) ? cmd_head.count : rc_ff;
   assign tail_m  = (32'(lc_ff) < 32'(TAIL_LEN)) ? lc_ff : CNT_W'(TAIL_LEN);
   assign lc_m1   = lc_ff - CNT_W'(1);
   assign rc_m1   = rc_ff - CNT_W'(1);
   assign is_full = ((CNT_W+1)'(lc_ff) + (CNT_W+1)'(rc_ff)) >= (CNT_W+1)'(CAP);

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && (cmd_head.op == OP_MOVE_LEFT || cmd_head.op == OP_MOVE_RIGHT)) begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (rem_ff == '0) begin
               state_in = ST_TAIL_SETUP;
            end
         end
         ST_TAIL_SETUP: begin
            if (room) begin
               state_in = (lc_ff == '0) ? ST_IDLE : ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (rem_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: counts, stack accesses and result pushes.
   always_comb begin
      lc_in        = lc_ff;
      rc_in        = rc_ff;
      rem_in       = rem_ff;
      addr_in      = addr_ff;
      dir_left_in  = dir_left_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      left_re      = 1'b0;
      left_raddr   = '0;
      left_we      = 1'b0;
      left_waddr   = '0;
      left_wdata   = '0;
      right_re     = 1'b0;
      right_raddr  = '0;
      right_we     = 1'b0;
      right_waddr  = '0;
      right_wdata  = '0;
      rq_push      = 1'b0;
      rq_wdata     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (cmd_head.op)
                  OP_INSERT: begin
                     rq_push           = 1'b1;
                     rq_wdata.kind     = KIND_INS;
                     rq_wdata.full_res = is_full;
                     rq_wdata.last     = 1'b1;
                     if (!is_full) begin
                        left_we    = 1'b1;
                        left_waddr = lc_ff[ADDR_W-1:0];
                        left_wdata = cmd_head.chr;
                        lc_in      = lc_ff + CNT_W'(1);
                     end
                  end
                  OP_DELETE: begin
                     lc_in            = lc_ff - n_left;
                     rq_push          = 1'b1;
                     rq_wdata.kind    = KIND_DEL;
                     rq_wdata.deleted = DEL_W'(n_left);
                     rq_wdata.last    = 1'b1;
                  end
                  OP_MOVE_LEFT: begin
                     dir_left_in = 1'b1;
                     rem_in      = n_left;
                  end
                  OP_MOVE_RIGHT: begin
                     dir_left_in = 1'b0;
                     rem_in      = n_right;
                  end
                  default: ;
               endcase
            end
         end
         ST_MOVE: begin
            // Pop the source top: the read data arrives next cycle.
            if (rem_ff != '0) begin
               rem_in  = rem_ff - CNT_W'(1);
               pend_in = 1'b1;
               if (dir_left_ff) begin
                  left_re    = 1'b1;
                  left_raddr = lc_m1[ADDR_W-1:0];
                  lc_in      = lc_m1;
               end else begin
                  right_re    = 1'b1;
                  right_raddr = rc_m1[ADDR_W-1:0];
                  rc_in       = rc_m1;
               end
            end
            // Push the character read last cycle onto the other stack.
            if (pend_ff) begin
               if (dir_left_ff) begin
                  right_we    = 1'b1;
                  right_waddr = rc_ff[ADDR_W-1:0];
                  right_wdata = left_rd_ff;
                  rc_in       = rc_ff + CNT_W'(1);
               end else begin
                  left_we    = 1'b1;
                  left_waddr = lc_ff[ADDR_W-1:0];
                  left_wdata = right_rd_ff;
                  lc_in      = lc_ff + CNT_W'(1);
               end
            end
         end
         ST_TAIL_SETUP: begin
            if (room) begin
               if (lc_ff == '0) begin
                  rq_push       = 1'b1;
                  rq_wdata.kind = KIND_EMPTY;
                  rq_wdata.last = 1'b1;
               end else begin
                  rem_in  = tail_m;
                  addr_in = ADDR_W'(lc_ff - tail_m);
               end
            end
         end
         ST_TAIL: begin
            // Deliver the character read last cycle.
            if (pend_ff) begin
               rq_push       = 1'b1;
               rq_wdata.kind = KIND_CHR;
               rq_wdata.chr  = left_rd_ff;
               rq_wdata.last = pend_last_ff;
            end
            // Read the next tail character while a result slot is free.
            if (rem_ff != '0 && room) begin
               left_re      = 1'b1;
               left_raddr   = addr_ff;
               addr_in      = addr_ff + 1'b1;
               rem_in       = rem_ff - CNT_W'(1);
               pend_in      = 1'b1;
               pend_last_in = (rem_ff == CNT_W'(1));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lc_ff        <= '0;
         rc_ff        <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         dir_left_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         rc_ff        <= rc_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         dir_left_ff  <= dir_left_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   // Left stack: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[left_waddr] <= left_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (left_re) begin
         left_rd_ff <= left_mem[left_raddr];
      end
   end

   // Right stack: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem[right_waddr] <= right_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (right_re) begin
         right_rd_ff <= right_mem[right_raddr];
      end
   end

   // Result queue control.
   assign rsp_empty = (rq_cnt_ff == '0);
   assign rq_pop    = rsp_pop & ~rsp_empty;
   assign rq_head   = rq_ff[rq_rd_ptr_ff];

   always_comb begin
      rq_wr_ptr_in = rq_wr_ptr_ff;
      rq_rd_ptr_in = rq_rd_ptr_ff;
      if (rq_push) begin
         rq_wr_ptr_in = (rq_wr_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rq_wr_ptr_ff + 1'b1;
      end
      if (rq_pop) begin
         rq_rd_ptr_in = (rq_rd_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rq_rd_ptr_ff + 1'b1;
      end
      rq_cnt_in = rq_cnt_ff + RSPQ_CNT_W'(rq_push) - RSPQ_CNT_W'(rq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ptr_ff <= '0;
         rq_rd_ptr_ff <= '0;
         rq_cnt_ff    <= '0;
      end else begin
         rq_wr_ptr_ff <= rq_wr_ptr_in;
         rq_rd_ptr_ff <= rq_rd_ptr_in;
         rq_cnt_ff    <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wr_ptr_ff] <= rq_wdata;
      end
   end

   // Result beat on the ports.
   assign rsp_kind     = rq_head.kind;
   assign rsp_deleted  = rq_head.deleted;
   assign rsp_char_out = rq_head.chr;
   assign rsp_full_res = rq_head.full_res;
   assign rsp_last     = rq_head.last;

   // The two stacks together never hold more than the capacity.
   `CLEBC_ASSERT_ALWAYS(a_cap_bound, clock, reset, ((CNT_W+1)'(lc_ff) + (CNT_W+1)'(rc_ff)) <= (CNT_W+1)'(CAP), "stack counts exceed capacity")
   // Reserved result slots never overrun the result queue.
   `CLEBC_ASSERT_ALWAYS(a_rspq_bound, clock, reset, rq_slots <= (RSPQ_CNT_W+1)'(RSPQ_DEPTH), "result queue overrun")
   // A finished transfer always continues with the tail readout.
   `CLEBC_ASSERT_NEXT(a_move_done, clock, reset, state_ff == ST_MOVE && rem_ff == '0, state_ff == ST_TAIL_SETUP, "move did not proceed to tail")
   // A pending read only exists while moving or reading the tail.
   `CLEBC_ASSERT_IMPL(a_pend_ctx, clock, reset, pend_ff, state_ff == ST_MOVE || state_ff == ST_TAIL, "stray pending read")
   // The tail character flagged last is the final one read.
   `CLEBC_ASSERT_IMPL(a_tail_last, clock, reset, pend_ff && pend_last_ff && state_ff == ST_TAIL, rem_ff == '0, "last flag before end of tail")

endmodule

// ===== design/cursor_line_edit_buffer_core.sv =====
// Top level of the cursor line-edit buffer: front end plus back end.
// Depends on clebc_pkg, clebc_front and clebc_back.
`timescale 1ns / 1ps

// A bounded text line with a cursor, held as two stacks of up to CAP
// characters in total. Commands (insert, delete left, move left/right) go
// in through a two-beat command queue; results come out of a four-beat
// result queue, so a stall on either side is buffered by the queues. An
// insert or delete is executed in the cycle the back end takes it. A move
// of k characters transfers them at one character per cycle through the
// single read and write port of each stack memory, then reads back the
// m = min(10, characters before the cursor) characters before the cursor
// one per cycle from the left stack while a result slot is free. The stack
// memories are not cleared after reset; only written entries are read.
module cursor_line_edit_buffer_core import clebc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [CHAR_W-1:0]  req_char_in,
   input  logic [COUNT_W-1:0] req_count,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [DEL_W-1:0]   rsp_deleted,
   output logic [CHAR_W-1:0]  rsp_char_out,
   output logic               rsp_full_res,
   output logic               rsp_last
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_head;

   // Command intake and decode.
   clebc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_mode    (req_mode),
      .req_char_in (req_char_in),
      .req_count   (req_count),
      .cmd_valid   (cmd_valid),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop)
   );

   // Stack execution and result delivery.
   clebc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_head     (cmd_head),
      .cmd_pop      (cmd_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_kind     (rsp_kind),
      .rsp_deleted  (rsp_deleted),
      .rsp_char_out (rsp_char_out),
      .rsp_full_res (rsp_full_res),
      .rsp_last     (rsp_last)
   );

endmodule
